// ===== sv/tcpq_pkg.sv =====
// Shared types and constants of the two-class priority queue.
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

    typedef enum logic [1:0] {
        ST_QUEUED  = 2'd0,
        ST_SERVED  = 2'd1,
        ST_DROPPED = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_SERVE  = 1'b1;

    localparam int         THRESH_BITS  = 7;
    localparam int         AGE_BITS     = 7;
    localparam logic [6:0] THRESH_RESET = 7'd54;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_flags;

endpackage

`default_nettype wire

// ===== sv/tcpq_if.sv =====
// Valid/ready channel interfaces for the arrival/serve requests and the results.
`timescale 1ns / 1ps
`default_nettype none

interface tcpq_in_if
    import tcpq_pkg::*;
#(
    parameter int TAG_BITS = 64
);
    logic                valid;
    logic                ready;
    logic                action;
    logic [TAG_BITS-1:0] client_tag;
    logic [AGE_BITS-1:0] client_age;

    modport source (output valid, output action, output client_tag, output client_age,
                    input ready);
    modport sink   (input valid, input action, input client_tag, input client_age,
                    output ready);
endinterface

interface tcpq_out_if
    import tcpq_pkg::*;
#(
    parameter int TAG_BITS = 64,
    parameter int CNT_BITS = 11
);
    logic                valid;
    logic                ready;
    t_status             status;
    logic [TAG_BITS-1:0] served_tag;
    logic                from_priority;
    logic [CNT_BITS-1:0] priority_count;
    logic [CNT_BITS-1:0] regular_count;

    modport source (output valid, output status, output served_tag, output from_priority,
                    output priority_count, output regular_count, input ready);
    modport sink   (input valid, input status, input served_tag, input from_priority,
                    input priority_count, input regular_count, output ready);
endinterface

`default_nettype wire

// ===== sv/tcpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/tcpq_fifo.sv =====
// Ring-buffer FIFO with a look-ahead read so the head entry is ready every cycle.
`timescale 1ns / 1ps
`default_nettype none

module tcpq_fifo
    import tcpq_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_fifo_cmd                  i_cmd,
    input  wire logic [WIDTH-1:0]           i_wdata,
    output logic      [WIDTH-1:0]           o_head_data,
    output t_fifo_flags                     o_flags,
    output logic      [$clog2(DEPTH+1)-1:0] o_next_count
);

    localparam int               AW      = $clog2(DEPTH);
    localparam int               CW      = $clog2(DEPTH + 1);
    localparam logic [AW:0]      DEPTH_W = DEPTH[AW:0];
    localparam logic [CW-1:0]    DEPTH_C = DEPTH[CW-1:0];

    logic [AW-1:0]    r_head;
    logic [AW-1:0]    n_head;
    logic [CW-1:0]    r_fill;
    logic [CW-1:0]    n_fill;
    logic [AW:0]      tail_sum;
    logic [AW:0]      tail_wrap;
    logic [AW-1:0]    tail;
    logic [AW:0]      head_inc;
    logic [WIDTH-1:0] ram_q;
    logic             r_byp;
    logic [WIDTH-1:0] r_byp_data;

    // Pushes only happen below full, so the fill fits in AW bits here.
    assign tail_sum  = {1'b0, r_head} + {1'b0, r_fill[AW-1:0]};
    assign tail_wrap = tail_sum - DEPTH_W;
    assign tail      = (tail_sum >= DEPTH_W) ? tail_wrap[AW-1:0] : tail_sum[AW-1:0];
    assign head_inc  = {1'b0, r_head} + {{AW{1'b0}}, 1'b1};

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_cmd.pop) begin
            n_head = (head_inc == DEPTH_W) ? '0 : head_inc[AW-1:0];
            n_fill = r_fill - {{(CW-1){1'b0}}, 1'b1};
        end else if (i_cmd.push) begin
            n_fill = r_fill + {{(CW-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_byp  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            // Forward a write that lands on the slot being read this cycle.
            r_byp  <= i_cmd.push && (tail == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_wdata;
    end

    tcpq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (tail),
        .i_wdata (i_wdata),
        .i_raddr (n_head),
        .o_rdata (ram_q)
    );

    assign o_head_data   = r_byp ? r_byp_data : ram_q;
    assign o_flags.full  = (r_fill == DEPTH_C);
    assign o_flags.empty = (r_fill == '0);
    assign o_next_count  = n_fill;

endmodule

`default_nettype wire

// ===== sv/two_class_priority_queue_top.sv =====
// Two-class strict-priority queue: request register, two ring FIFOs, result register.
//
// Usage:
//   i_in carries one request per transaction: action arrive (tag, age) or serve.
//   An arrival with age strictly above the threshold joins the priority FIFO,
//   otherwise the regular FIFO; a full target FIFO drops it (status dropped).
//   A serve pops the priority head if any, else the regular head, else reports
//   empty. Each request gives exactly one transaction on o_res with the status,
//   served tag (zero unless served), class and both occupancies after it.
//   A request passes through the request and result registers. Throughput: one
//   request per cycle while o_res does not stall; each is at most one RAM write
//   or one head pop plus a count update, and the next head is read ahead through the
//   registered RAM port with a forward path for a slot written the cycle before.
//   When o_res stalls, the result register holds and one more request is taken
//   into the request register; ready then drops until o_res moves.
//   i_cfg_we writes the age threshold (reset value 54); write only while idle.
//   Reset (synchronous, active low) empties both FIFOs and drops any pending
//   request or result; the RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module two_class_priority_queue_top
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024,
    parameter int TAG_BITS    = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [THRESH_BITS-1:0] i_cfg_wdata,
    tcpq_in_if.sink                     i_in,
    tcpq_out_if.source                  o_res
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [THRESH_BITS-1:0] r_thresh;

    logic                r_in_vld;
    logic                r_act;
    logic [TAG_BITS-1:0] r_tag;
    logic [AGE_BITS-1:0] r_age;

    logic                r_out_vld;
    t_status             r_status;
    logic [TAG_BITS-1:0] r_served;
    logic                r_cls;
    logic [CW-1:0]       r_pcount;
    logic [CW-1:0]       r_rcount;

    logic                advance;
    logic                in_take;
    t_fifo_cmd           p_cmd;
    t_fifo_cmd           g_cmd;
    t_fifo_flags         p_flags;
    t_fifo_flags         g_flags;
    logic [TAG_BITS-1:0] p_head;
    logic [TAG_BITS-1:0] g_head;
    logic [CW-1:0]       p_next;
    logic [CW-1:0]       g_next;

    t_status             n_status;
    logic [TAG_BITS-1:0] n_served;
    logic                n_cls;

    assign advance     = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_in.ready  = !r_in_vld || advance;
    assign in_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_act <= i_in.action;
            r_tag <= i_in.client_tag;
            r_age <= i_in.client_age;
        end
    end

    // Classify and route the held request.
    always_comb begin
        p_cmd    = '0;
        g_cmd    = '0;
        n_status = ST_EMPTY;
        n_served = '0;
        n_cls    = 1'b0;
        if (r_act == ACT_ARRIVE) begin
            n_cls = (r_age > r_thresh);
            if (n_cls ? p_flags.full : g_flags.full) begin
                n_status = ST_DROPPED;
            end else begin
                n_status   = ST_QUEUED;
                p_cmd.push = advance && n_cls;
                g_cmd.push = advance && !n_cls;
            end
        end else if (!p_flags.empty) begin
            n_status  = ST_SERVED;
            n_served  = p_head;
            n_cls     = 1'b1;
            p_cmd.pop = advance;
        end else if (!g_flags.empty) begin
            n_status  = ST_SERVED;
            n_served  = g_head;
            g_cmd.pop = advance;
        end
    end

    tcpq_fifo #(
        .WIDTH (TAG_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_prio_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (p_cmd),
        .i_wdata      (r_tag),
        .o_head_data  (p_head),
        .o_flags      (p_flags),
        .o_next_count (p_next)
    );

    tcpq_fifo #(
        .WIDTH (TAG_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_reg_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (g_cmd),
        .i_wdata      (r_tag),
        .o_head_data  (g_head),
        .o_flags      (g_flags),
        .o_next_count (g_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status <= n_status;
            r_served <= n_served;
            r_cls    <= n_cls;
            r_pcount <= p_next;
            r_rcount <= g_next;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.status         = r_status;
    assign o_res.served_tag     = r_served;
    assign o_res.from_priority  = r_cls;
    assign o_res.priority_count = r_pcount;
    assign o_res.regular_count  = r_rcount;

endmodule

`default_nettype wire

// ===== sv/tcpq_checker.sv =====
// Port-level checker for the two-class priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcpq_checker
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024,
    parameter int TAG_BITS    = 64
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_out_valid,
    input wire logic                               i_out_ready,
    input wire t_status                            i_status,
    input wire logic [TAG_BITS-1:0]                i_served_tag,
    input wire logic                               i_from_priority,
    input wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_priority_count,
    input wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_regular_count
);

    localparam int                  CW    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0]       FULLC = QUEUE_DEPTH[CW-1:0];

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_served_tag) && $stable(i_priority_count)
            && $stable(i_regular_count))
        else $error("stalled result changed");

    a_drop_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_DROPPED |->
            (i_from_priority ? (i_priority_count == FULLC) : (i_regular_count == FULLC)))
        else $error("arrival dropped with room in its queue");

    a_empty_serve : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |->
            i_priority_count == '0 && i_regular_count == '0 && !i_from_priority
            && i_served_tag == '0)
        else $error("empty serve with entries present");

endmodule

bind two_class_priority_queue_top tcpq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
) u_tcpq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_status         (o_res.status),
    .i_served_tag     (o_res.served_tag),
    .i_from_priority  (o_res.from_priority),
    .i_priority_count (o_res.priority_count),
    .i_regular_count  (o_res.regular_count)
);

`default_nettype wire
